// ===== src/rob_pkg.sv =====
// shared types, constants and helpers for the reorder buffer
// no dependencies; imported by rob_ctrl, rob_datapath and reorder_buffer
`default_nettype none
package rob_pkg;

  localparam int ROB_DEPTH   = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(ROB_DEPTH);
  localparam int CNT_W       = $clog2(ROB_DEPTH + 1);

  // request command codes
  localparam logic [1:0] CMD_ALLOC    = 2'd0;
  localparam logic [1:0] CMD_COMPLETE = 2'd1;
  localparam logic [1:0] CMD_COMMIT   = 2'd2;
  localparam logic [1:0] CMD_FLUSH    = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FAIL     = 2'd1;
  localparam logic [1:0] STAT_MISMATCH = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_HALT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRANCH = 1'd1;
  localparam logic [CFG_DATA_W-1:0] HALT_RESET   = 5'd0;
  localparam logic [CFG_DATA_W-1:0] BRANCH_RESET = 5'd1;

  typedef logic [4:0]             op_kind_t;
  typedef logic [31:0]            pc_t;
  typedef logic [5:0]             dest_t;
  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [4:0]             occ_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  typedef struct packed {
    logic [1:0]         command;
    op_kind_t           op_kind;
    pc_t                pc;
    dest_t              dest_reg;
    logic signed [31:0] result_value;
    logic               executed;
    logic               result_ready;
  } rob_item_t;

  typedef struct packed {
    logic [1:0]         status;
    op_kind_t           out_op_kind;
    pc_t                out_pc;
    dest_t              out_dest_reg;
    logic signed [31:0] out_value;
    logic               out_ready;
    logic               out_exception;
    logic               out_busy;
    occ_t               occupancy;
    logic               can_accept;
  } rob_result_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic match;
    logic apply;
  } rob_cmd_t;

  function automatic idx_t next_idx(input idx_t i);
    return (i == idx_t'(ROB_DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
  endfunction

endpackage
`default_nettype wire

// ===== src/rob_ctrl.sv =====
// sequencing controller: accept, match, apply and result register handshake
// depends on rob_pkg
`default_nettype none
module rob_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_stall,
  output logic                result_valid,
  input  wire logic           result_stall,
  output rob_pkg::rob_cmd_t   cmd
);
  import rob_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MATCH = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       result_valid_next;
  logic       out_blocked;

  assign out_blocked = result_valid && result_stall;
  assign item_stall  = rst || (state != ST_IDLE);

  always_comb begin
    cmd.load  = (state == ST_IDLE) && item_valid && !rst;
    cmd.match = (state == ST_MATCH);
    cmd.apply = (state == ST_APPLY) && !out_blocked;
  end

  always_comb begin
    case (state)
      ST_IDLE:  state_next = cmd.load ? ST_MATCH : ST_IDLE;
      ST_MATCH: state_next = ST_APPLY;
      ST_APPLY: state_next = cmd.apply ? ST_IDLE : ST_APPLY;
      default:  state_next = ST_IDLE;
    endcase
  end

  // result register stays full until taken, refilled by the next apply
  assign result_valid_next = cmd.apply || out_blocked;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  a_load_then_match: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.match)
    else $error("match did not follow request load");

  a_match_then_apply: assert property (@(posedge clk) disable iff (rst)
    state == ST_MATCH |=> state == ST_APPLY)
    else $error("match stage not followed by apply stage");

  a_apply_fills_result: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |=> result_valid)
    else $error("apply did not present a result");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && state != ST_APPLY) |=> !result_valid)
    else $error("taken result not released");

endmodule
`default_nettype wire

// ===== src/rob_datapath.sv =====
// reorder buffer entries, pointers, pc search and result register
// depends on rob_pkg; sequenced by rob_ctrl
`default_nettype none
module rob_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire rob_pkg::rob_cmd_t                  cmd,
  input  wire rob_pkg::rob_item_t                 item,
  input  wire logic                               cfg_write,
  input  wire logic [rob_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rob_pkg::CFG_DATA_W-1:0]     cfg_data,
  output rob_pkg::rob_result_t                    result
);
  import rob_pkg::*;

  rob_item_t              req;
  op_kind_t               halt_code;
  op_kind_t               branch_code;

  logic [ROB_DEPTH-1:0]   busy;
  logic [ROB_DEPTH-1:0]   ready;
  logic [ROB_DEPTH-1:0]   excp;
  op_kind_t               etype  [ROB_DEPTH];
  pc_t                    epc    [ROB_DEPTH];
  dest_t                  edest  [ROB_DEPTH];
  value_t                 evalue [ROB_DEPTH];
  idx_t                   head;
  idx_t                   tail;
  cnt_t                   count;

  logic                   found;
  idx_t                   found_idx;
  logic                   dest_ok;
  logic                   found_c;
  idx_t                   found_idx_c;
  logic                   dest_ok_c;

  logic [ROB_DEPTH-1:0]   busy_next;
  logic [ROB_DEPTH-1:0]   ready_next;
  idx_t                   head_next;
  idx_t                   tail_next;
  cnt_t                   count_next;
  rob_result_t            res_next;
  logic                   do_alloc;
  logic                   do_complete;

  // lowest busy entry whose pc matches, with its destination check
  always_comb begin
    found_c     = 1'b0;
    found_idx_c = '0;
    dest_ok_c   = 1'b0;
    for (int j = ROB_DEPTH - 1; j >= 0; j--) begin
      if (busy[j] && (epc[j] == req.pc)) begin
        found_c     = 1'b1;
        found_idx_c = idx_t'(j);
        dest_ok_c   = (edest[j] == req.dest_reg);
      end
    end
  end

  always_comb begin
    busy_next   = busy;
    ready_next  = ready;
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    do_alloc    = 1'b0;
    do_complete = 1'b0;
    res_next        = '0;
    res_next.status = STAT_FAIL;
    case (req.command)
      CMD_ALLOC: begin
        if ((count < cnt_t'(ROB_DEPTH)) && !busy[tail]) begin
          do_alloc          = 1'b1;
          busy_next[tail]   = 1'b1;
          ready_next[tail]  = (req.op_kind == halt_code);
          count_next        = count + cnt_t'(1);
          tail_next         = next_idx(tail);
          res_next.status   = STAT_OK;
        end
      end
      CMD_COMPLETE: begin
        if (req.executed && found) begin
          if (dest_ok) begin
            do_complete           = 1'b1;
            ready_next[found_idx] = req.result_ready;
            res_next.status       = STAT_OK;
          end else begin
            res_next.status = STAT_MISMATCH;
          end
        end
      end
      CMD_COMMIT: begin
        if (ready[head]) begin
          res_next.out_op_kind   = etype[head];
          res_next.out_pc        = epc[head];
          res_next.out_dest_reg  = edest[head];
          res_next.out_value     = 32'(evalue[head]);
          res_next.out_ready     = 1'b1;
          res_next.out_exception = excp[head];
          res_next.out_busy      = busy[head];
          busy_next[head]        = 1'b0;
          ready_next[head]       = 1'b0;
          if (count != '0) begin
            count_next = count - cnt_t'(1);
          end
          head_next       = next_idx(head);
          res_next.status = STAT_OK;
        end
      end
      CMD_FLUSH: begin
        busy_next       = '0;
        ready_next      = '0;
        head_next       = '0;
        tail_next       = '0;
        count_next      = '0;
        res_next.status = STAT_OK;
      end
      default: ;
    endcase
    res_next.occupancy  = occ_t'(count_next);
    res_next.can_accept = (count_next < cnt_t'(ROB_DEPTH)) && !busy_next[tail_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= '0;
      ready       <= '0;
      head        <= '0;
      tail        <= '0;
      count       <= '0;
      halt_code   <= HALT_RESET;
      branch_code <= BRANCH_RESET;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_HALT:   halt_code   <= cfg_data;
          CFG_BRANCH: branch_code <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.apply) begin
        busy  <= busy_next;
        ready <= ready_next;
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
      end
    end
  end

  // entry payload only matters while the entry is busy
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= item;
    end
    if (cmd.match) begin
      found     <= found_c;
      found_idx <= found_idx_c;
      dest_ok   <= dest_ok_c;
    end
    if (cmd.apply) begin
      result <= res_next;
      if (do_alloc) begin
        etype[tail]  <= req.op_kind;
        epc[tail]    <= req.pc;
        edest[tail]  <= req.dest_reg;
        evalue[tail] <= '1;
        excp[tail]   <= 1'b0;
      end
      if (do_complete) begin
        evalue[found_idx] <= value_t'(req.result_value);
        if (req.op_kind == branch_code) begin
          excp[found_idx] <= req.result_ready;
        end
      end
    end
  end

  a_count_matches_busy: assert property (@(posedge clk) disable iff (rst)
    $countones(busy) == int'(count))
    else $error("entry count disagrees with busy entries");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(ROB_DEPTH))
    else $error("entry count beyond depth");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.apply && req.command == CMD_FLUSH) |=> (count == '0 && busy == '0 && head == tail))
    else $error("flush left entries behind");

  a_ready_implies_busy: assert property (@(posedge clk) disable iff (rst)
    (ready & ~busy) == '0)
    else $error("ready entry not busy");

endmodule
`default_nettype wire

// ===== src/reorder_buffer.sv =====
// Reorder buffer, 16 entries, in-order circular allocation and retirement.
// Request channel: item_valid / item_stall with an item struct carrying the
// command (allocate, complete, commit head, flush), type, pc, destination,
// value and flags. A request is taken on a clock edge with item_valid high
// and item_stall low. Every request gives exactly one result on the
// result channel (result_valid / result_stall): status, the retired entry
// on a successful commit, occupancy and whether an allocate would succeed.
// Timing: a request is held in the request register, its pc search result
// in the match registers, then the apply state updates the entries and the
// result register; a new request is taken only once the previous one is
// applied. The pc search is combinational over all entries and registered.
// The result register holds while result_stall is high; the next request
// is still taken and worked up to its update, which waits for the register.
// Config: cfg_write with cfg_index 0 writes the halt type code, 1 the
// branch type code; write only while no request is in flight.
// Reset (synchronous, rst high) empties the buffer, clears both pointers,
// sets halt code 0 and branch code 1, and drops result_valid.
`default_nettype none
module reorder_buffer (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               item_valid,
  output logic                                    item_stall,
  input  wire rob_pkg::rob_item_t                 item,
  output logic                                    result_valid,
  input  wire logic                               result_stall,
  output rob_pkg::rob_result_t                    result,
  input  wire logic                               cfg_write,
  input  wire logic [rob_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rob_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rob_pkg::*;

  rob_cmd_t cmd;

  rob_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd)
  );

  rob_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item      (item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

endmodule
`default_nettype wire

// ===== bench/reorder_buffer_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for reorder_buffer: a directed table, then random phases
// under several type-code settings; depends on rob_pkg and the reorder_buffer rtl

module reorder_buffer_tb;
  import rob_pkg::*;

  typedef struct {
    rob_item_t   req;
    bit          typed;
    rob_result_t want;
  } table_row_t;

  logic                  clk;
  logic                  rst;
  logic                  item_valid;
  logic                  item_stall;
  rob_item_t             item;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  rob_result_t           result;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // buffer shadow used to predict each result
  logic       rob_busy  [ROB_DEPTH];
  op_kind_t   rob_type  [ROB_DEPTH];
  pc_t        rob_pc    [ROB_DEPTH];
  dest_t      rob_dest  [ROB_DEPTH];
  value_t     rob_value [ROB_DEPTH];
  logic       rob_exc   [ROB_DEPTH];
  logic       rob_rdy   [ROB_DEPTH];
  int         rob_head;
  int         rob_tail;
  int         rob_count;
  op_kind_t   halt_code;
  op_kind_t   branch_code;

  rob_result_t pending_results[$];
  int          mismatch_count = 0;
  int          stall_left = 0;
  bit          sender_calm = 1'b0;
  bit          receiver_calm = 1'b0;

  reorder_buffer dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout, results still outstanding: %0d", $time, pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

  function automatic void clear_buffer();
    for (int j = 0; j < ROB_DEPTH; j++) begin
      rob_busy[j]  = 1'b0;
      rob_type[j]  = '0;
      rob_pc[j]    = '0;
      rob_dest[j]  = '0;
      rob_value[j] = '0;
      rob_exc[j]   = 1'b0;
      rob_rdy[j]   = 1'b0;
    end
    rob_head  = 0;
    rob_tail  = 0;
    rob_count = 0;
  endfunction

  function automatic logic slot_free();
    return rob_count < ROB_DEPTH && !rob_busy[rob_tail];
  endfunction

  function automatic rob_result_t predict_buffer(input rob_item_t req);
    rob_result_t res;
    int          hit;
    int          h;
    res = '0;
    res.status = STAT_FAIL;
    case (req.command)
      CMD_ALLOC: begin
        if (slot_free()) begin
          rob_busy[rob_tail]  = 1'b1;
          rob_type[rob_tail]  = req.op_kind;
          rob_pc[rob_tail]    = req.pc;
          rob_dest[rob_tail]  = req.dest_reg;
          rob_value[rob_tail] = '1;
          rob_exc[rob_tail]   = 1'b0;
          rob_rdy[rob_tail]   = (req.op_kind == halt_code);
          rob_count++;
          rob_tail = (rob_tail + 1) % ROB_DEPTH;
          res.status = STAT_OK;
        end
      end
      CMD_COMPLETE: begin
        if (req.executed) begin
          hit = -1;
          for (int j = 0; j < ROB_DEPTH; j++)
            if (hit < 0 && rob_busy[j] && rob_pc[j] == req.pc) hit = j;
          if (hit >= 0) begin
            if (rob_dest[hit] == req.dest_reg) begin
              rob_value[hit] = value_t'(req.result_value);
              rob_rdy[hit] = req.result_ready;
              // branch test looks at the request type, not the stored one
              if (req.op_kind == branch_code) rob_exc[hit] = req.result_ready;
              res.status = STAT_OK;
            end else begin
              res.status = STAT_MISMATCH;
            end
          end
        end
      end
      CMD_COMMIT: begin
        h = rob_head;
        if (rob_rdy[h]) begin
          res.out_op_kind   = rob_type[h];
          res.out_pc        = rob_pc[h];
          res.out_dest_reg  = rob_dest[h];
          res.out_value     = rob_value[h][31:0];
          res.out_ready     = rob_rdy[h];
          res.out_exception = rob_exc[h];
          res.out_busy      = rob_busy[h];
          rob_busy[h]  = 1'b0;
          rob_type[h]  = '0;
          rob_pc[h]    = '0;
          rob_dest[h]  = '0;
          rob_value[h] = '0;
          rob_exc[h]   = 1'b0;
          rob_rdy[h]   = 1'b0;
          if (rob_count > 0) rob_count--;
          rob_head = (h + 1) % ROB_DEPTH;
          res.status = STAT_OK;
        end
      end
      default: begin
        clear_buffer();
        res.status = STAT_OK;
      end
    endcase
    res.occupancy  = occ_t'(rob_count);
    res.can_accept = slot_free();
    return res;
  endfunction

  function automatic rob_item_t make_req(input logic [1:0] cmd, input op_kind_t kind,
                                         input pc_t pc, input dest_t dest,
                                         input logic [31:0] val, input logic exe,
                                         input logic rdy);
    rob_item_t req;
    req.command      = cmd;
    req.op_kind      = kind;
    req.pc           = pc;
    req.dest_reg     = dest;
    req.result_value = val;
    req.executed     = exe;
    req.result_ready = rdy;
    return req;
  endfunction

  function automatic rob_result_t status_only(input logic [1:0] st, input int occ,
                                              input logic can);
    rob_result_t res;
    res = '0;
    res.status     = st;
    res.occupancy  = occ_t'(occ);
    res.can_accept = can;
    return res;
  endfunction

  function automatic int idle_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // mostly requests that hit live entries and the configured type codes
  function automatic rob_item_t random_request(input int alloc_pct, input int commit_pct);
    rob_item_t req;
    int        r;
    int        pick;
    int        live[$];
    req.op_kind      = op_kind_t'($urandom);
    req.pc           = $urandom;
    req.dest_reg     = dest_t'($urandom);
    req.result_value = $urandom;
    req.executed     = 1'($urandom_range(0, 1));
    req.result_ready = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 1) req.command = CMD_FLUSH;
    else if (r < 1 + alloc_pct) req.command = CMD_ALLOC;
    else if (r < 1 + alloc_pct + commit_pct) req.command = CMD_COMMIT;
    else req.command = CMD_COMPLETE;
    // small pc pool so duplicate tags show up
    if ($urandom_range(0, 1)) req.pc = 32'h0000_1000 + ($urandom_range(0, 7) << 2);
    case (req.command)
      CMD_ALLOC: begin
        r = $urandom_range(0, 9);
        if (r < 4) req.op_kind = halt_code;
        else if (r < 6) req.op_kind = branch_code;
      end
      CMD_COMPLETE: begin
        foreach (rob_busy[j]) if (rob_busy[j]) live.push_back(j);
        if (live.size() != 0 && $urandom_range(0, 99) < 85) begin
          pick = live[$urandom_range(0, live.size() - 1)];
          req.pc = rob_pc[pick];
          if ($urandom_range(0, 99) < 85) req.dest_reg = rob_dest[pick];
        end
        if ($urandom_range(0, 99) < 40) req.op_kind = branch_code;
        req.executed     = $urandom_range(0, 99) < 90;
        req.result_ready = $urandom_range(0, 99) < 85;
      end
      default: ;
    endcase
    return req;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void check_result(input rob_result_t got);
    rob_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result with nothing expected, got %h", $time, got);
      mismatch_count++;
      return;
    end
    want = pending_results.pop_front();
    compare_field("status", 32'(want.status), 32'(got.status));
    compare_field("out_op_kind", 32'(want.out_op_kind), 32'(got.out_op_kind));
    compare_field("out_pc", want.out_pc, got.out_pc);
    compare_field("out_dest_reg", 32'(want.out_dest_reg), 32'(got.out_dest_reg));
    compare_field("out_value", want.out_value, got.out_value);
    compare_field("out_ready", 32'(want.out_ready), 32'(got.out_ready));
    compare_field("out_exception", 32'(want.out_exception), 32'(got.out_exception));
    compare_field("out_busy", 32'(want.out_busy), 32'(got.out_busy));
    compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
    compare_field("can_accept", 32'(want.can_accept), 32'(got.can_accept));
  endfunction

  // result side: check on accept, random stall bursts
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) check_result(result);
    if (stall_left != 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
      if (!receiver_calm && $urandom_range(0, 3) == 0) stall_left = idle_gap(1'b0);
    end
  end

  // called at a rising edge; returns at the edge the request was taken, or after a random idle gap
  task automatic send_request(input rob_item_t req);
    int gap;
    item_valid <= 1'b1;
    item <= req;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    gap = idle_gap(sender_calm);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_type_codes(input op_kind_t halt, input op_kind_t branch);
    cfg_write <= 1'b1;
    cfg_index <= CFG_HALT;
    cfg_data  <= halt;
    @(posedge clk);
    cfg_index <= CFG_BRANCH;
    cfg_data  <= branch;
    @(posedge clk);
    cfg_write <= 1'b0;
    halt_code   = halt;
    branch_code = branch;
  endtask

  initial begin
    table_row_t  rows[$];
    rob_item_t   req;
    rob_result_t predicted;
    op_kind_t    halt;
    op_kind_t    branch;
    int          alloc_pct;
    int          commit_pct;

    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_write  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    clear_buffer();
    halt_code   = HALT_RESET;
    branch_code = BRANCH_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset type codes: halt 0, branch 1
    rows.push_back('{make_req(CMD_COMMIT, '0, '0, '0, '0, 1'b0, 1'b0),
                     1'b1, status_only(STAT_FAIL, 0, 1'b1)});
    rows.push_back('{make_req(CMD_COMPLETE, '0, '0, '0, '0, 1'b0, 1'b1),
                     1'b1, status_only(STAT_FAIL, 0, 1'b1)});
    rows.push_back('{make_req(CMD_ALLOC, HALT_RESET, '0, '0, '0, 1'b0, 1'b0),
                     1'b1, status_only(STAT_OK, 1, 1'b1)});
    rows.push_back('{make_req(CMD_COMMIT, '0, '0, '0, '0, 1'b0, 1'b0), 1'b0, '0});
    rows.push_back('{make_req(CMD_ALLOC, 5'd31, 32'hFFFF_FFFF, 6'd63, '1, 1'b1, 1'b1),
                     1'b1, status_only(STAT_OK, 1, 1'b1)});
    rows.push_back('{make_req(CMD_COMPLETE, 5'd31, 32'hFFFF_FFFF, 6'd0, '1, 1'b1, 1'b1),
                     1'b1, status_only(STAT_MISMATCH, 1, 1'b1)});
    rows.push_back('{make_req(CMD_COMPLETE, 5'd31, 32'h1234_5678, 6'd63, '1, 1'b1, 1'b1),
                     1'b1, status_only(STAT_FAIL, 1, 1'b1)});
    rows.push_back('{make_req(CMD_COMPLETE, 5'd31, 32'hFFFF_FFFF, 6'd63, 32'h8000_0000,
                              1'b1, 1'b1), 1'b1, status_only(STAT_OK, 1, 1'b1)});
    rows.push_back('{make_req(CMD_COMMIT, '0, '0, '0, '0, 1'b0, 1'b0), 1'b0, '0});
    // two entries sharing a pc: complete hits the lower index
    rows.push_back('{make_req(CMD_ALLOC, BRANCH_RESET, 32'h0000_1000, 6'd5, '0, 1'b0, 1'b0),
                     1'b0, '0});
    rows.push_back('{make_req(CMD_ALLOC, BRANCH_RESET, 32'h0000_1000, 6'd6, '0, 1'b0, 1'b0),
                     1'b0, '0});
    rows.push_back('{make_req(CMD_COMPLETE, BRANCH_RESET, 32'h0000_1000, 6'd5, 32'h7FFF_FFFF,
                              1'b1, 1'b1), 1'b0, '0});
    rows.push_back('{make_req(CMD_COMPLETE, BRANCH_RESET, 32'h0000_1000, 6'd6, '0, 1'b1, 1'b1),
                     1'b0, '0});
    rows.push_back('{make_req(CMD_COMMIT, '0, '0, '0, '0, 1'b0, 1'b0), 1'b0, '0});
    rows.push_back('{make_req(CMD_COMMIT, '0, '0, '0, '0, 1'b0, 1'b0), 1'b0, '0});
    rows.push_back('{make_req(CMD_COMPLETE, 5'd3, 32'h0000_1000, 6'd6, '0, 1'b1, 1'b0),
                     1'b0, '0});
    rows.push_back('{make_req(CMD_COMMIT, '0, '0, '0, '0, 1'b0, 1'b0), 1'b0, '0});
    rows.push_back('{make_req(CMD_COMPLETE, BRANCH_RESET, 32'h0000_1000, 6'd6, 32'd1,
                              1'b1, 1'b1), 1'b0, '0});
    rows.push_back('{make_req(CMD_COMMIT, '0, '0, '0, '0, 1'b0, 1'b0), 1'b0, '0});
    rows.push_back('{make_req(CMD_ALLOC, 5'd7, 32'hAAAA_5555, 6'h2A, '0, 1'b0, 1'b0),
                     1'b0, '0});
    rows.push_back('{make_req(CMD_COMPLETE, 5'd7, 32'hAAAA_5555, 6'h2A, '0, 1'b0, 1'b1),
                     1'b1, status_only(STAT_FAIL, 1, 1'b1)});
    rows.push_back('{make_req(CMD_FLUSH, '1, '1, '1, '1, 1'b1, 1'b1),
                     1'b1, status_only(STAT_OK, 0, 1'b1)});
    rows.push_back('{make_req(CMD_COMMIT, '0, '0, '0, '0, 1'b0, 1'b0),
                     1'b1, status_only(STAT_FAIL, 0, 1'b1)});

    foreach (rows[i]) begin
      predicted = predict_buffer(rows[i].req);
      pending_results.push_back(rows[i].typed ? rows[i].want : predicted);
      send_request(rows[i].req);
    end

    // random phases, each under its own pair of type codes
    for (int p = 0; p < 7; p++) begin
      drain_results();
      case (p)
        0: begin halt = 5'd31; branch = 5'd0;  end
        1: begin halt = 5'd0;  branch = 5'd31; end
        2: begin halt = 5'd5;  branch = 5'd5;  end
        3: begin halt = 5'd31; branch = 5'd31; end
        4: begin halt = HALT_RESET; branch = BRANCH_RESET; end
        default: begin
          halt   = op_kind_t'($urandom);
          branch = op_kind_t'($urandom);
        end
      endcase
      set_type_codes(halt, branch);
      sender_calm   = $urandom_range(0, 3) == 0;
      receiver_calm = $urandom_range(0, 3) == 0;
      // odd phases lean on allocate to reach a full buffer
      alloc_pct  = (p % 2 == 1) ? 55 : 35;
      commit_pct = (p % 2 == 1) ? 20 : 27;
      for (int n = 0; n < 250; n++) begin
        if ($urandom_range(0, 199) == 0) drain_results();
        req = random_request(alloc_pct, commit_pct);
        pending_results.push_back(predict_buffer(req));
        send_request(req);
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
